### rtl/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg: shared types and constants of the postfix truth table evaluator
// Token codes, config register indexes, the table-load struct and helpers
// that clamp the variable count and build variable columns.
// ----------------------------------------------------------------------------
`default_nettype none

package pte_pkg;

  // widths fixed by the interface
  localparam int unsigned MAX_VARS   = 6;
  localparam int unsigned ROWS_MAX   = 64;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned NVARS_W    = 3;
  localparam int unsigned LETTER_W   = 8;
  localparam int unsigned LETTERS_W  = 48;
  localparam int unsigned CFG_IDX_W  = 1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTERS  = 1'b1;

  // operator characters
  localparam logic [7:0] TOK_NOT = 8'h21;  // '!'
  localparam logic [7:0] TOK_AND = 8'h26;  // '&'
  localparam logic [7:0] TOK_OR  = 8'h7c;  // '|'
  localparam logic [7:0] TOK_IMP = 8'h3e;  // '>'
  localparam logic [7:0] TOK_EQV = 8'h3d;  // '='

  // letter ranges
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;

  // finished column handed to the row emitter
  typedef struct packed {
    logic [ROWS_MAX-1:0] col;
    logic                err;
    logic [NVARS_W-1:0]  nvars;
  } load_t;

  // clamp the configured variable count to 1..MAX_VARS
  function automatic logic [NVARS_W-1:0] active_vars(input logic [NVARS_W-1:0] num);
    logic [NVARS_W-1:0] n;
    n = num;
    if (n == '0) n = NVARS_W'(1);
    if (n > NVARS_W'(MAX_VARS)) n = NVARS_W'(MAX_VARS);
    return n;
  endfunction

  // truth table column of the variable at row-index bit position shift
  function automatic logic [ROWS_MAX-1:0] var_column(input logic [NVARS_W-1:0] shift);
    logic [ROWS_MAX-1:0] col;
    logic [ROW_W-1:0]    rv;
    col = '0;
    for (int r = 0; r < ROWS_MAX; r++) begin
      rv     = ROW_W'(r) >> shift;
      col[r] = rv[0];
    end
    return col;
  endfunction

endpackage

`default_nettype wire

### rtl/pte_ram.sv
// ----------------------------------------------------------------------------
// pte_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered, read-before-write.
// ----------------------------------------------------------------------------
`default_nettype none

module pte_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/pte_row_emitter.sv
// ----------------------------------------------------------------------------
// pte_row_emitter: truth table row output stage
// Holds a finished column; one row beat per cycle, in row order, while ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pte_row_emitter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             load_i,
  input  wire pte_pkg::load_t                   load_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [pte_pkg::ROW_W-1:0]        row_index_o,
  output logic                                  value_o,
  output logic                                  error_o,
  output logic                                  last_row_o
);

  logic                            busy_q, busy_d;
  logic [pte_pkg::ROWS_MAX-1:0]    col_q, col_d;
  logic                            err_q, err_d;
  logic [pte_pkg::ROW_W-1:0]       row_q, row_d;
  logic [pte_pkg::ROW_W-1:0]       final_q, final_d;
  logic                            beat;

  assign beat = busy_q && out_ready_i;

  // next row, or a fresh table
  always_comb begin
    busy_d  = busy_q;
    col_d   = col_q;
    err_d   = err_q;
    row_d   = row_q;
    final_d = final_q;
    if (load_i) begin
      busy_d  = 1'b1;
      col_d   = load_data_i.col;
      err_d   = load_data_i.err;
      row_d   = '0;
      final_d = pte_pkg::ROW_W'((7'd1 << load_data_i.nvars) - 7'd1);
    end else if (beat) begin
      if (row_q == final_q) begin
        busy_d = 1'b0;
      end else begin
        row_d = row_q + pte_pkg::ROW_W'(1);
        col_d = col_q >> 1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    err_q   <= err_d;
    row_q   <= row_d;
    final_q <= final_d;
  end

  assign out_valid_o = busy_q;
  assign row_index_o = row_q;
  assign value_o     = col_q[0] && !err_q;
  assign error_o     = err_q;
  assign last_row_o  = row_q == final_q;

endmodule

`default_nettype wire

### rtl/postfix_truth_table_evaluator.sv
// Output: the rows of a table start the cycle after its last token and go out
// one beat per cycle while ready, 2^n beats with n the clamped num_vars.
// Throughput: one token per cycle; a last token waits while the previous table
// is still draining from the row register.
// Reset: stack count, error flag, config and row stage busy flag clear
// at once; stack contents are undefined until pushed.
// ----------------------------------------------------------------------------
// postfix_truth_table_evaluator: postfix boolean expression truth table
// Evaluates all variable assignments at once on 64-bit columns; the top two
// stack entries live in registers and the rest in a RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_truth_table_evaluator #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pte_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [pte_pkg::LETTERS_W-1:0]      cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [7:0]                         token_i,
  input  wire logic                               last_token_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [pte_pkg::ROW_W-1:0]          row_index_o,
  output logic                                    value_o,
  output logic                                    error_o,
  output logic                                    last_row_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW_ = pte_pkg::ROWS_MAX;

  logic [pte_pkg::NVARS_W-1:0]   num_vars_q;
  logic [pte_pkg::LETTERS_W-1:0] letters_q;
  logic [CW-1:0]                 count_q, count_d;
  logic                          err_q, err_d;
  logic [CW_-1:0]                top_q, top_d;
  logic [CW_-1:0]                next_q, next_d;
  logic                          byp_q, byp_d;
  logic [CW_-1:0]                byp_data_q;
  logic [CW_-1:0]                third;
  logic [CW_-1:0]                ram_rdata;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [pte_pkg::NVARS_W-1:0]   n_act;
  logic                          is_alpha, found;
  logic [pte_pkg::NVARS_W-1:0]   which;
  logic [CW_-1:0]                push_col;
  logic                          tok_ok;
  logic                          load;
  pte_pkg::load_t                load_data;
  logic                          emit_busy;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vars_q <= pte_pkg::NVARS_W'(1);
      letters_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pte_pkg::CFG_NUM_VARS: num_vars_q <= cfg_data_i[pte_pkg::NVARS_W-1:0];
        pte_pkg::CFG_LETTERS:  letters_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign n_act = pte_pkg::active_vars(num_vars_q);

  // letter decode, highest matching variable wins
  always_comb begin
    is_alpha = (token_i >= pte_pkg::CH_UPPER_A && token_i <= pte_pkg::CH_UPPER_Z) ||
               (token_i >= pte_pkg::CH_LOWER_A && token_i <= pte_pkg::CH_LOWER_Z);
    found = 1'b0;
    which = '0;
    for (int i = 0; i < pte_pkg::MAX_VARS; i++) begin
      if (pte_pkg::NVARS_W'(i) < n_act &&
          letters_q[i*pte_pkg::LETTER_W +: pte_pkg::LETTER_W] == token_i) begin
        found = 1'b1;
        which = pte_pkg::NVARS_W'(i);
      end
    end
    push_col = pte_pkg::var_column(n_act - pte_pkg::NVARS_W'(1) - which);
  end

  // third entry from the RAM, with forwarding of a same-cycle write
  assign third = byp_q ? byp_data_q : ram_rdata;

  // a last token waits for the row stage to drain
  assign in_ready_o = !last_token_i || !emit_busy;
  assign tok_ok     = in_valid_i && in_ready_o;

  // at most one stack operation per token
  always_comb begin
    count_d   = count_q;
    err_d     = err_q;
    top_d     = top_q;
    next_d    = next_q;
    ram_we    = 1'b0;
    ram_waddr = AW'(count_q - CW'(2));
    load      = 1'b0;
    load_data = '0;
    if (tok_ok) begin
      if (is_alpha) begin
        if (!found || count_q == CW'(STACK_DEPTH)) begin
          err_d = 1'b1;
        end else begin
          top_d   = push_col;
          next_d  = top_q;
          ram_we  = count_q >= CW'(2);
          count_d = count_q + CW'(1);
        end
      end else begin
        case (token_i)
          pte_pkg::TOK_NOT: begin
            if (count_q == '0) err_d = 1'b1;
            else top_d = ~top_q;
          end
          pte_pkg::TOK_AND, pte_pkg::TOK_OR, pte_pkg::TOK_IMP, pte_pkg::TOK_EQV: begin
            if (count_q < CW'(2)) begin
              err_d = 1'b1;
            end else begin
              case (token_i)
                pte_pkg::TOK_AND: top_d = next_q & top_q;
                pte_pkg::TOK_OR:  top_d = next_q | top_q;
                pte_pkg::TOK_IMP: top_d = ~next_q | top_q;
                default:          top_d = ~(next_q ^ top_q);
              endcase
              next_d  = third;
              count_d = count_q - CW'(1);
            end
          end
          default: ;
        endcase
      end
      // end of expression: hand the top column to the row stage
      if (last_token_i) begin
        load            = 1'b1;
        load_data.col   = top_d;
        load_data.err   = err_d || count_d == '0;
        load_data.nvars = n_act;
        count_d         = '0;
        err_d           = 1'b0;
      end
    end
    ram_raddr = AW'(count_d - CW'(3));
    byp_d     = ram_we && ram_waddr == ram_raddr;
  end

  // stack control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      err_q   <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      err_q   <= err_d;
      byp_q   <= byp_d;
    end
  end

  // top two columns and forwarded write data
  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    next_q     <= next_d;
    byp_data_q <= next_q;
  end

  // lower stack entries
  pte_ram #(
    .WIDTH (CW_),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (next_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // row output stage
  pte_row_emitter u_rows (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .load_data_i (load_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_index_o (row_index_o),
    .value_o     (value_o),
    .error_o     (error_o),
    .last_row_o  (last_row_o)
  );

  assign emit_busy = out_valid_o;

`ifndef SYNTHESIS
  // a table is only loaded into an idle row stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_token_i) |-> !out_valid_o)
    else $error("last token accepted while rows still pending");

  // an accepted last token clears the stack and starts a table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_token_i) |=> (count_q == '0 && !err_q && out_valid_o))
    else $error("stack not cleared or table not started after last token");

  // error rows always read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> !value_o)
    else $error("error row with nonzero value");

  // stack count never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
`endif

endmodule

`default_nettype wire

### tb/pte_row_checker.sv
// ----------------------------------------------------------------------------
// pte_row_checker: truth table row checker
// Watches the config port and both beat channels, keeps its own stack of
// truth-table columns, builds the expected rows of each finished expression
// and compares every output beat against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pte_row_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pte_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [pte_pkg::LETTERS_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [7:0]                    token_i,
  input  wire logic                          last_token_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [pte_pkg::ROW_W-1:0]     row_index_i,
  input  wire logic                          value_i,
  input  wire logic                          error_i,
  input  wire logic                          last_row_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        rows_pending_o,
  output int unsigned                        rows_checked_o
);
  import pte_pkg::*;

  localparam int unsigned STACK_SLOTS = 32;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             value;
    logic             error;
    logic             last;
  } row_beat_t;

  row_beat_t           expected_rows[$];
  logic [ROWS_MAX-1:0] columns [STACK_SLOTS];
  int unsigned         depth_used;
  bit                  fault_seen;
  logic [NVARS_W-1:0]  nvars_reg;
  logic [LETTERS_W-1:0] letters_reg;
  int unsigned         mismatches = 0;
  int unsigned         rows_checked = 0;
  int unsigned         pending_rows = 0;

  assign fail_count_o   = mismatches;
  assign rows_pending_o = pending_rows;
  assign rows_checked_o = rows_checked;

  // variable count actually in force
  function automatic int unsigned clamp_vars(input logic [NVARS_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_VARS) return MAX_VARS;
    return raw;
  endfunction

  // column of one variable: bit r is that variable's value in row r
  function automatic logic [ROWS_MAX-1:0] literal_column(input int unsigned var_no,
                                                         input int unsigned n);
    logic [ROWS_MAX-1:0] col;
    int unsigned         sh;
    sh = n - 1 - var_no;
    for (int r = 0; r < ROWS_MAX; r++) col[r] = 1'((r >> sh) & 1);
    return col;
  endfunction

  // one stack step, plus the table rows when the token is the last one
  function automatic void absorb_token(input logic [7:0] t, input logic last);
    logic [ROWS_MAX-1:0] lhs, rhs, res, top_col;
    int unsigned         n, rows, hit;
    bit                  found, is_letter;
    row_beat_t           beat;
    n = clamp_vars(nvars_reg);
    is_letter = (t >= CH_UPPER_A && t <= CH_UPPER_Z) || (t >= CH_LOWER_A && t <= CH_LOWER_Z);
    if (is_letter) begin
      found = 0;
      hit = 0;
      // highest matching variable wins
      for (int i = 0; i < n; i++) begin
        if (letters_reg[8*i +: 8] == t) begin
          found = 1;
          hit = i;
        end
      end
      if (!found || depth_used >= STACK_SLOTS) begin
        fault_seen = 1;
      end else begin
        columns[depth_used] = literal_column(hit, n);
        depth_used++;
      end
    end else if (t == TOK_NOT) begin
      if (depth_used < 1) fault_seen = 1;
      else columns[depth_used-1] = ~columns[depth_used-1];
    end else if (t == TOK_AND || t == TOK_OR || t == TOK_IMP || t == TOK_EQV) begin
      if (depth_used < 2) begin
        fault_seen = 1;
      end else begin
        rhs = columns[depth_used-1];
        lhs = columns[depth_used-2];
        case (t)
          TOK_AND: res = lhs & rhs;
          TOK_OR:  res = lhs | rhs;
          TOK_IMP: res = ~lhs | rhs;
          default: res = ~(lhs ^ rhs);
        endcase
        depth_used--;
        columns[depth_used-1] = res;
      end
    end
    if (!last) return;

    // emit the table with the variable count in force now
    if (depth_used == 0) fault_seen = 1;
    top_col = '0;
    if (!fault_seen) top_col = columns[depth_used-1];
    rows = 1 << n;
    for (int r = 0; r < rows; r++) begin
      beat.row   = ROW_W'(r);
      beat.value = fault_seen ? 1'b0 : top_col[r];
      beat.error = fault_seen;
      beat.last  = (r == rows - 1);
      expected_rows = {expected_rows, beat};
    end
    depth_used = 0;
    fault_seen = 0;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // compare one output beat with the oldest expected row
  task automatic check_row();
    row_beat_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch("row with no table pending", row_index_i, 0);
    end else begin
      want = expected_rows.pop_front();
      if (row_index_i !== want.row) report_mismatch("row_index", row_index_i, want.row);
      if (value_i !== want.value) report_mismatch("value", value_i, want.value);
      if (error_i !== want.error) report_mismatch("error", error_i, want.error);
      if (last_row_i !== want.last) report_mismatch("last_row", last_row_i, want.last);
    end
    rows_checked++;
  endtask

  // track config writes and both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nvars_reg   <= NVARS_W'(1);
      letters_reg <= '0;
      depth_used  = 0;
      fault_seen  = 0;
      expected_rows.delete();
      pending_rows = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_NUM_VARS) nvars_reg <= cfg_data_i[NVARS_W-1:0];
        else if (cfg_index_i == CFG_LETTERS) letters_reg <= cfg_data_i;
      end
      if (out_valid_i && out_ready_i) check_row();
      if (in_valid_i && in_ready_i) absorb_token(token_i, last_token_i);
      pending_rows = expected_rows.size();
    end
  end

endmodule

### tb/tb_postfix_truth_table_evaluator.sv
// ----------------------------------------------------------------------------
// tb_postfix_truth_table_evaluator: testbench of the truth table evaluator
// Sends directed and random postfix expressions under several variable
// settings, with random idle bursts on both channels; the row checker
// predicts every table row and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_postfix_truth_table_evaluator;
  import pte_pkg::*;

  localparam int unsigned ITEM_TARGET = 450;
  localparam int unsigned QUIET_AFTER = 390;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NUM_VARS;
  logic [LETTERS_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           token = '0;
  logic                 last_token = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ROW_W-1:0]     row_index;
  logic                 row_value;
  logic                 row_error;
  logic                 last_row;

  int unsigned fail_count, rows_pending, rows_checked;

  // stimulus state
  logic [7:0]           expr_buf[$];
  int unsigned          items_sent = 0;
  int unsigned          phase_no = 0;
  int unsigned          cur_vars = 1;
  logic [LETTERS_W-1:0] cur_letters = '0;
  bit                   no_idle = 0;

  postfix_truth_table_evaluator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .token_i     (token),
    .last_token_i(last_token),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .row_index_o (row_index),
    .value_o     (row_value),
    .error_o     (row_error),
    .last_row_o  (last_row)
  );

  pte_row_checker row_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .token_i       (token),
    .last_token_i  (last_token),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .row_index_i   (row_index),
    .value_i       (row_value),
    .error_i       (row_error),
    .last_row_i    (last_row),
    .fail_count_o  (fail_count),
    .rows_pending_o(rows_pending),
    .rows_checked_o(rows_checked)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  // output side: ready stretches with random stall bursts
  initial begin
    @(posedge clk);
    forever begin
      if (no_idle || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  // append one character to the pending expression
  function automatic void add_char(input logic [7:0] t);
    expr_buf = {expr_buf, t};
  endfunction

  function automatic bit is_letter(input logic [7:0] t);
    return (t >= CH_UPPER_A && t <= CH_UPPER_Z) || (t >= CH_LOWER_A && t <= CH_LOWER_Z);
  endfunction

  function automatic bit is_operator(input logic [7:0] t);
    return t == TOK_NOT || t == TOK_AND || t == TOK_OR || t == TOK_IMP || t == TOK_EQV;
  endfunction

  function automatic logic [7:0] pick_binary_op();
    case ($urandom_range(0, 3))
      0:       return TOK_AND;
      1:       return TOK_OR;
      2:       return TOK_IMP;
      default: return TOK_EQV;
    endcase
  endfunction

  function automatic logic [7:0] pick_alpha();
    if ($urandom_range(0, 1)) return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
    return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
  endfunction

  // a character the block ignores
  function automatic logic [7:0] pick_noise();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    while (is_letter(t) || is_operator(t)) t = 8'($urandom_range(0, 255));
    return t;
  endfunction

  // an alphabetic code that names none of the active variables
  function automatic logic [7:0] pick_unknown();
    logic [7:0] t;
    bit         clash;
    clash = 1;
    t = 8'h00;
    while (clash) begin
      t = pick_alpha();
      clash = 0;
      for (int i = 0; i < cur_vars; i++) if (cur_letters[8*i +: 8] == t) clash = 1;
    end
    return t;
  endfunction

  function automatic logic [7:0] var_letter();
    return cur_letters[8*$urandom_range(0, cur_vars - 1) +: 8];
  endfunction

  // six letter codes, distinct unless duplicates are wanted
  function automatic logic [LETTERS_W-1:0] pick_letters(input bit allow_dups);
    logic [LETTERS_W-1:0] codes;
    logic [7:0]           t;
    bit                   clash;
    codes = '0;
    for (int i = 0; i < MAX_VARS; i++) begin
      if (allow_dups && i > 0 && $urandom_range(0, 1)) begin
        t = codes[8*$urandom_range(0, i - 1) +: 8];
      end else begin
        clash = 1;
        t = 8'h00;
        while (clash) begin
          t = pick_alpha();
          clash = 0;
          for (int j = 0; j < i; j++) if (codes[8*j +: 8] == t) clash = 1;
        end
      end
      codes[8*i +: 8] = t;
    end
    return codes;
  endfunction

  // one config write; cfg_we drops again before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LETTERS_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_NUM_VARS) begin
      cur_vars = data[NVARS_W-1:0];
      if (cur_vars == 0) cur_vars = 1;
      if (cur_vars > MAX_VARS) cur_vars = MAX_VARS;
    end else begin
      cur_letters = data;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // num_vars write with random don't-care upper bits
  task automatic write_vars(input int unsigned raw);
    logic [LETTERS_W-1:0] data;
    data = LETTERS_W'({$urandom, $urandom});
    data[NVARS_W-1:0] = NVARS_W'(raw);
    write_reg(CFG_NUM_VARS, data);
  endtask

  // stop sending and wait until every expected row is out
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (rows_pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one token beat, with an optional idle burst ahead of it
  task automatic send_token(input logic [7:0] t, input bit last);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    token      <= t;
    last_token <= last;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // send the buffered expression; a positive split changes num_vars part way
  task automatic send_expr(input int split);
    for (int i = 0; i < expr_buf.size(); i++) begin
      if (split > 0 && i == split) begin
        settle();
        write_vars($urandom_range(0, 7));
      end
      send_token(expr_buf[i], i == expr_buf.size() - 1);
    end
  endtask

  task automatic load_text(input string s);
    expr_buf.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // append a well-formed random formula over the active variables
  task automatic build_formula(input int unsigned leaves);
    int unsigned depth, placed;
    depth = 0;
    placed = 0;
    while (placed < leaves || depth > 1) begin
      if (depth >= 1 && $urandom_range(0, 5) == 0) begin
        add_char(TOK_NOT);
      end else if (placed < leaves && (depth < 2 || $urandom_range(0, 1))) begin
        add_char(var_letter());
        placed++;
        depth++;
      end else begin
        add_char(pick_binary_op());
        depth--;
      end
      if ($urandom_range(0, 15) == 0) add_char(pick_noise());
    end
  endtask

  // one random expression, mostly well formed
  task automatic random_expr();
    int unsigned kind, split;
    kind = $urandom_range(0, 11);
    split = 0;
    expr_buf.delete();
    if (kind < 8) begin
      build_formula($urandom_range(0, 3) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 6));
      if (expr_buf.size() > 1 && $urandom_range(0, 9) == 0)
        split = $urandom_range(1, expr_buf.size() - 1);
    end else if (kind == 8) begin
      // raw bytes
      repeat ($urandom_range(1, 10)) add_char(8'($urandom_range(0, 255)));
    end else if (kind == 9) begin
      // more pushes than the stack holds
      repeat ($urandom_range(33, 36)) add_char(var_letter());
      repeat ($urandom_range(0, 4)) add_char(pick_binary_op());
    end else if (kind == 10) begin
      // operator before any operand
      add_char($urandom_range(0, 1) ? TOK_NOT : pick_binary_op());
      build_formula($urandom_range(1, 4));
    end else begin
      // letter naming no variable
      build_formula($urandom_range(1, 4));
      add_char(pick_unknown());
      if ($urandom_range(0, 1)) add_char(pick_binary_op());
    end
    send_expr(split);
  endtask

  // main stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two variables a and b
    write_vars(2);
    write_reg(CFG_LETTERS, 48'h0000_0000_6261);
    load_text("ab&");  send_expr(0);
    load_text("ab|");  send_expr(0);
    load_text("ab>");  send_expr(0);
    load_text("ab=!"); send_expr(0);
    // underflow with an empty stack at the end
    load_text("&");    send_expr(0);
    // unknown letter
    load_text("ac");   send_expr(0);
    // only an ignored character
    load_text(" ");    send_expr(0);
    // extra entry below the top
    load_text("ab");   send_expr(0);
    // extreme ignored codes around a push
    expr_buf.delete();
    add_char(8'h00);
    add_char("a");
    add_char(8'hff);
    send_expr(0);

    // random phases, each under its own setting
    while (items_sent < ITEM_TARGET) begin
      settle();
      case (phase_no)
        0: begin
          write_vars(0);
          write_reg(CFG_LETTERS, pick_letters(0));
        end
        1: write_vars(7);
        2: write_vars(1);
        3: begin
          write_vars(6);
          write_reg(CFG_LETTERS, pick_letters(1));
        end
        4: write_reg(CFG_LETTERS, '1);
        default: begin
          write_vars($urandom_range(0, 7));
          write_reg(CFG_LETTERS, pick_letters($urandom_range(0, 3) == 0));
        end
      endcase
      repeat (phase_no == 4 ? 2 : $urandom_range(4, 8)) begin
        if (items_sent >= QUIET_AFTER) no_idle = 1;
        if (items_sent < ITEM_TARGET) random_expr();
      end
      phase_no++;
    end

    settle();
    repeat (16) @(posedge clk);
    $display("covered %0d tokens over %0d settings, %0d table rows checked",
             items_sent, phase_no + 1, rows_checked);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/pte_pkg.sv
rtl/pte_ram.sv
rtl/pte_row_emitter.sv
rtl/postfix_truth_table_evaluator.sv
tb/pte_row_checker.sv
tb/tb_postfix_truth_table_evaluator.sv
